FILE: design/rrtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtq_pkg
// Shared types and codes for the round-robin task queue.
// ----------------------------------------------------------------------------
package rrtq_pkg;

    localparam int ID_W   = 16;
    localparam int SKIP_W = 8;

    localparam logic [SKIP_W-1:0] SKIP_LIMIT = 8'hFF;

    // Operation codes
    localparam logic [2:0] MODE_ENQ   = 3'd0;
    localparam logic [2:0] MODE_DEQ   = 3'd1;
    localparam logic [2:0] MODE_PICK  = 3'd2;
    localparam logic [2:0] MODE_YIELD = 3'd3;
    localparam logic [2:0] MODE_HALT  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ID_W-1:0]   task_id;
        logic              halt_sleep;
        logic [SKIP_W-1:0] skip_start;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] chosen_id;
        logic            chosen_valid;
        logic [1:0]      status;
        logic [10:0]     occupancy;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              halt;
        logic [SKIP_W-1:0] skip;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       enq;
        logic       find_init;
        logic       mod_start;
        logic       mod_take;
        logic       rd_idx;
        logic       rd_last;
        logic       wr_skip;
        logic       wr_halt;
        logic       wr_move;
        logic       hit_latch;
        logic       cnt_dec;
        logic       lin_adv;
        logic       wrap_adv;
        logic       pos_inc;
        logic       restore;
        logic       res_load;
        logic       res_pick;
        logic [1:0] res_status;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] mode;
        logic       cnt_zero;
        logic       cnt_full;
        logic       match;
        logic       runnable;
        logic       iter_last;
        logic       mod_done;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: design/rrtq_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtq_mod
// Iterative remainder unit: 32-bit dividend modulo the entry count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrtq_mod #(
    parameter int CW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [CW-1:0] remainder
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    step_reg, step_next;
    logic [31:0]   dvd_reg, dvd_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   shifted;
    logic [CW:0]   diff;

    // Shift in the next dividend bit and subtract where it fits
    assign shifted = {rem_reg, dvd_reg[31]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 5'd31;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (shifted >= {1'b0, divisor})
                rem_next = diff[CW-1:0];
            else
                rem_next = shifted[CW-1:0];
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/rrtq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtq_dp
// Datapath: entry memory, count, scan position, scan index and the
// output register.
// ----------------------------------------------------------------------------
module rrtq_dp #(
    parameter int MAX_ENTRIES = 1024,
    parameter int ID_BITS     = 16,
    parameter int CW          = 11,
    parameter int AW          = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rrtq_pkg::req_t     req,
    input  rrtq_pkg::dp_cmd_t  cmd,
    output rrtq_pkg::dp_stat_t stat,
    input  logic               res_stall,
    output logic               res_valid,
    output rrtq_pkg::rsp_t     res
);

    localparam logic [rrtq_pkg::ID_W-1:0] ID_MASK = (ID_BITS >= rrtq_pkg::ID_W) ?
        {rrtq_pkg::ID_W{1'b1}} : rrtq_pkg::ID_W'((33'd1 << ID_BITS) - 33'd1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    rrtq_pkg::entry_t mem [MAX_ENTRIES];

    rrtq_pkg::req_t   item_reg;
    rrtq_pkg::entry_t rd_data_reg;
    rrtq_pkg::rsp_t   res_reg;
    logic             res_valid_reg;
    logic [CW-1:0]    count_reg;
    logic [31:0]      pos_reg;
    logic [31:0]      saved_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    iter_reg;
    logic [AW-1:0]    hit_reg;
    logic [AW-1:0]    k0_reg;

    logic [CW-1:0]    cnt_m1;
    logic [CW-1:0]    idx_inc;
    logic [CW+10:0]   occ_wide;
    logic             mod_done;
    logic [CW-1:0]    mod_rem;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    rrtq_pkg::entry_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    assign cnt_m1   = count_reg - CW'(1);
    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign occ_wide = {11'b0, count_reg};

    rrtq_mod #(.CW(CW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (pos_reg),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Select the write port
    always_comb
    begin
        wr_en   = cmd.enq | cmd.wr_skip | cmd.wr_halt | cmd.wr_move;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.enq)
        begin
            wr_addr = count_reg[AW-1:0];
            wr_data = '{id: item_reg.task_id, halt: item_reg.halt_sleep,
                        skip: item_reg.skip_start};
        end
        else if (cmd.wr_skip)
            wr_data.skip = rd_data_reg.skip + 8'd1;
        else if (cmd.wr_halt)
            wr_data.halt = item_reg.halt_sleep;
        else if (cmd.wr_move)
            wr_addr = hit_reg;
    end

    assign rd_en   = cmd.rd_idx | cmd.rd_last;
    assign rd_addr = cmd.rd_last ? cnt_m1[AW-1:0] : idx_reg;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Latch the transaction and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= '{mode: req.mode, task_id: req.task_id & ID_MASK,
                          halt_sleep: req.halt_sleep, skip_start: req.skip_start};
        if (cmd.find_init)
        begin
            idx_reg  <= '0;
            iter_reg <= '0;
        end
        else if (cmd.mod_take)
        begin
            idx_reg   <= mod_rem[AW-1:0];
            k0_reg    <= mod_rem[AW-1:0];
            iter_reg  <= '0;
            saved_reg <= pos_reg;
        end
        else if (cmd.lin_adv)
        begin
            idx_reg  <= idx_inc[AW-1:0];
            iter_reg <= iter_reg + AW'(1);
        end
        else if (cmd.wrap_adv)
        begin
            idx_reg  <= (idx_inc == count_reg) ? '0 : idx_inc[AW-1:0];
            iter_reg <= iter_reg + AW'(1);
        end
        else if (cmd.restore)
            idx_reg <= k0_reg;
        if (cmd.hit_latch)
            hit_reg <= idx_reg;
    end

    // Count and scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cmd.enq)
                count_reg <= count_reg + CW'(1);
            else if (cmd.cnt_dec)
                count_reg <= cnt_m1;
            if (cmd.restore)
                pos_reg <= saved_reg + 32'd1;
            else if (cmd.pos_inc)
                pos_reg <= pos_reg + 32'd1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.res_load)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg.chosen_id    <= cmd.res_pick ? rd_data_reg.id : '0;
            res_reg.chosen_valid <= cmd.res_pick;
            res_reg.status       <= cmd.res_status;
            res_reg.occupancy    <= occ_wide[10:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        stat.mode      = item_reg.mode;
        stat.cnt_zero  = (count_reg == '0);
        stat.cnt_full  = (count_reg >= MAX_CNT);
        stat.match     = (rd_data_reg.id == item_reg.task_id);
        stat.runnable  = !rd_data_reg.halt || (rd_data_reg.skip == rrtq_pkg::SKIP_LIMIT);
        stat.iter_last = (CW'(iter_reg) == cnt_m1);
        stat.mod_done  = mod_done;
        stat.out_free  = !res_valid_reg || !res_stall;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count beyond capacity");
    a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |-> !stat.cnt_full)
        else $error("append into a full queue");
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.out_free)
        else $error("result overwrites an untaken transaction");
    a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> res_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

FILE: design/rrtq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtq_ctrl
// Controller: sequences each operation over the datapath.
// ----------------------------------------------------------------------------
module rrtq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                ready,
    input  rrtq_pkg::dp_stat_t  stat,
    output rrtq_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FRD, S_FCHK, S_MOVE, S_DIV,
        S_PRD, S_PCHK, S_PRDL, S_PLAST, S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       pick_reg, pick_next;

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        pick_next   = pick_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load    = 1'b1;
                    status_next = rrtq_pkg::ST_OK;
                    pick_next   = 1'b0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FIN;
                case (stat.mode)
                    rrtq_pkg::MODE_ENQ:
                    begin
                        if (stat.cnt_full)
                            status_next = rrtq_pkg::ST_FULL;
                        else
                            cmd.enq = 1'b1;
                    end
                    rrtq_pkg::MODE_DEQ, rrtq_pkg::MODE_HALT:
                    begin
                        if (stat.cnt_zero)
                            status_next = rrtq_pkg::ST_NOTFOUND;
                        else
                        begin
                            cmd.find_init = 1'b1;
                            state_next    = S_FRD;
                        end
                    end
                    rrtq_pkg::MODE_PICK:
                    begin
                        if (stat.cnt_zero)
                            status_next = rrtq_pkg::ST_EMPTY;
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    rrtq_pkg::MODE_YIELD:
                        cmd.pos_inc = 1'b1;
                    default:
                        state_next = S_FIN;
                endcase
            end
            // Linear search for the first matching id
            S_FRD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (stat.match)
                begin
                    cmd.hit_latch = 1'b1;
                    if (stat.mode == rrtq_pkg::MODE_DEQ)
                    begin
                        cmd.rd_last = 1'b1;
                        state_next  = S_MOVE;
                    end
                    else
                    begin
                        cmd.wr_halt = 1'b1;
                        state_next  = S_FIN;
                    end
                end
                else if (stat.iter_last)
                begin
                    status_next = rrtq_pkg::ST_NOTFOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.lin_adv = 1'b1;
                    state_next  = S_FRD;
                end
            end
            // Move the last entry into the freed slot
            S_MOVE:
            begin
                cmd.wr_move = 1'b1;
                cmd.cnt_dec = 1'b1;
                state_next  = S_FIN;
            end
            S_DIV:
            begin
                if (stat.mod_done)
                begin
                    cmd.mod_take = 1'b1;
                    state_next   = S_PRD;
                end
            end
            // Round-robin scan, bumping skip counters of halted entries
            S_PRD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (stat.runnable)
                begin
                    cmd.pos_inc = 1'b1;
                    pick_next   = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.wr_skip = 1'b1;
                    if (stat.iter_last)
                    begin
                        cmd.restore = 1'b1;
                        state_next  = S_PRDL;
                    end
                    else
                    begin
                        cmd.pos_inc  = 1'b1;
                        cmd.wrap_adv = 1'b1;
                        state_next   = S_PRD;
                    end
                end
            end
            // Nothing eligible: re-read the entry at the saved position
            S_PRDL:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_PLAST;
            end
            S_PLAST:
            begin
                pick_next  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_pick   = pick_reg;
                    cmd.res_status = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= rrtq_pkg::ST_OK;
            pick_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            pick_reg   <= pick_next;
        end
    end

endmodule

FILE: design/round_robin_task_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_queue_unit
// Run queue of task entries with append, remove, halt update, yield and a
// round-robin pick that skips halted tasks.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) takes one operation per
//   transaction; rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one
//   result per operation, in order.
//   Operations run one at a time; req_stall is low only while idle, and the
//   next transaction is taken the cycle after a result is loaded.
//   Append, yield and unused modes finish without a search; remove and halt
//   update search the entries linearly (remove then moves the last entry
//   into the freed slot); pick first takes the remainder of the scan
//   position by the count (one bit per cycle), then scans entries, and
//   re-reads the entry at the saved position when nothing is eligible. The
//   entry memory has one read and one write port.
//   Reset empties the queue and zeroes the scan position; entry memory is
//   not cleared, so the unit is ready at once.
//   A stalled result stays in the output register; an operation already
//   accepted finishes its work and waits for the register to free.
// ----------------------------------------------------------------------------
module round_robin_task_queue_unit #(
    parameter int MAX_ENTRIES = 1024,
    parameter int ID_BITS     = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rrtq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrtq_pkg::rsp_t rsp
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    rrtq_pkg::dp_cmd_t  cmd;
    rrtq_pkg::dp_stat_t stat;
    logic               ready;

    assign req_stall = !ready;

    rrtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .ready     (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrtq_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS),
        .CW          (CW),
        .AW          (AW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res_stall (rsp_stall),
        .res_valid (rsp_valid),
        .res       (rsp)
    );

endmodule
